// ===== hdl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants and types for the servo position P controller: field
// widths, register indexes and reset values, and fixed-point constants.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int ANGLE_W    = 17;  // Q.8 degrees, 0..69120
  localparam int STATE_W    = 25;  // Q.16 degrees filter state
  localparam int ERR_W      = 18;
  localparam int DRIVE_W    = 8;
  localparam int MAG_W      = 7;
  localparam int DUTY_W     = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [ANGLE_W-1:0] FULL_Q8    = 17'd69120;
  localparam logic [MAG_W-1:0]   FULL_DRIVE = 7'd100;

  // floor(2^32 / 100) for the duty scaling
  localparam int                 DUTY_SHIFT = 32;
  localparam logic [25:0]        DUTY_RECIP = 26'd42949672;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ALPHA      = 3'd0,
    CFG_DEADZONE   = 3'd1,
    CFG_SATURATION = 3'd2,
    CFG_GAIN       = 3'd3,
    CFG_LOW_STOP   = 3'd4,
    CFG_HIGH_STOP  = 3'd5,
    CFG_MIN_DRIVE  = 3'd6,
    CFG_PWM_TOP    = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] RST_ALPHA      = 16'd3277;
  localparam logic [16:0] RST_DEADZONE   = 17'd256;
  localparam logic [16:0] RST_SATURATION = 17'd12800;
  localparam logic [15:0] RST_GAIN       = 16'd512;
  localparam logic [16:0] RST_LOW_STOP   = 17'd1280;
  localparam logic [16:0] RST_HIGH_STOP  = 17'd67840;
  localparam logic [6:0]  RST_MIN_DRIVE  = 7'd12;
  localparam logic [23:0] RST_PWM_TOP    = 24'd89999;

endpackage

// ===== hdl/spc_in_if.sv =====
// ----------------------------------------------------------------------------
// spc_in_if
// Sample channel: one beat carries a setpoint and a position reading.
// ----------------------------------------------------------------------------
interface spc_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] setpoint_sample;
  logic [SAMPLE_BITS-1:0] position_sample;

  modport source (output valid, output setpoint_sample, output position_sample, input ready);
  modport sink   (input valid, input setpoint_sample, input position_sample, output ready);
endinterface

// ===== hdl/spc_out_if.sv =====
// ----------------------------------------------------------------------------
// spc_out_if
// Drive channel: one beat carries the drive command, direction, PWM compare
// value and the filtered error.
// ----------------------------------------------------------------------------
interface spc_out_if;
  import spc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_percent;
  logic                      forward;
  logic [DUTY_W-1:0]         duty_compare;
  logic signed [ERR_W-1:0]   error_angle;

  modport source (output valid, output drive_percent, output forward, output duty_compare,
                  output error_angle, input ready);
  modport sink   (input valid, input drive_percent, input forward, input duty_compare,
                  input error_angle, output ready);
endinterface

// ===== hdl/servo_position_p_controller_unit.sv =====
// ----------------------------------------------------------------------------
// servo_position_p_controller_unit
// Proportional position controller with deadzone, end-stop cutoff and PWM
// compare output.
//
// Usage:
//   in_ch  : one beat per control tick (setpoint and position readings).
//   out_ch : one beat per input beat (drive %, direction, duty, error).
//   cfg_*  : register writes, to be issued only while the block is idle.
// Timing:
//   An item runs through one shared signed multiplier under a sequencer:
//   two multiply/correct passes for the angle scaling, two for the
//   low-pass filters, one for the gain, and for the duty scaling two
//   multiplies and one correction. in_ch.ready is high only while the
//   sequencer is idle, so a new item is not taken until the last is done.
//   A finished result sits in the output register; the next item is taken
//   meanwhile, and its last step waits until out_ch.ready frees the register.
// Reset:
//   Registers go to their defaults, filter state to zero, no output pending.
// ----------------------------------------------------------------------------
module servo_position_p_controller_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  spc_in_if.sink                        in_ch,
  spc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [spc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spc_pkg::*;

  localparam int XW    = SAMPLE_BITS + ANGLE_W;          // scaled sample width
  localparam int MAW   = ((XW > 31) ? XW : 31) + 1;      // multiplier operand A
  localparam int MBW   = 27;                             // multiplier operand B
  localparam int PW    = MAW + MBW;
  localparam int ANG_K = XW;
  localparam logic [XW-1:0]  ANG_DIV   = XW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [XW-1:0]  ANG_HALF  = XW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [MBW-1:0] ANG_RECIP =
    MBW'((64'd1 << ANG_K) / ((64'd1 << SAMPLE_BITS) - 64'd1));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ASP_MUL, ST_ASP_FIX,
    ST_APS_MUL, ST_APS_FIX,
    ST_FSP_MUL, ST_FSP_FIX,
    ST_FPS_MUL, ST_FPS_FIX,
    ST_ERR,
    ST_GAIN_MUL, ST_GAIN_FIX,
    ST_DUTY_MUL, ST_RECIP_MUL, ST_DUTY_FIX
  } state_t;

  // configuration
  logic [15:0]        alpha_r;
  logic [16:0]        deadzone_r;
  logic [16:0]        saturation_r;
  logic [15:0]        gain_r;
  logic [16:0]        low_stop_r;
  logic [16:0]        high_stop_r;
  logic [MAG_W-1:0]   min_drive_r;
  logic [DUTY_W-1:0]  pwm_top_r;

  // datapath
  state_t                  state_r;
  logic [SAMPLE_BITS-1:0]  sp_smp_r, ps_smp_r;
  logic [ANGLE_W-1:0]      sp_ang_r, ps_ang_r;
  logic [STATE_W-1:0]      spf_r, psf_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ERR_W:0]   err_r;
  logic [ERR_W-1:0]        ae_r;
  logic                    neg_r;
  logic [ERR_W-1:0]        pos_q8_r;
  logic [MAG_W-1:0]        mag_r;
  logic [30:0]             dval_r;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic                      forward_r;
  logic [DUTY_W-1:0]         duty_r;
  logic [ERR_W-1:0]          error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= RST_ALPHA;
      deadzone_r   <= RST_DEADZONE;
      saturation_r <= RST_SATURATION;
      gain_r       <= RST_GAIN;
      low_stop_r   <= RST_LOW_STOP;
      high_stop_r  <= RST_HIGH_STOP;
      min_drive_r  <= RST_MIN_DRIVE;
      pwm_top_r    <= RST_PWM_TOP;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ALPHA:      alpha_r      <= cfg_wdata[15:0];
        CFG_DEADZONE:   deadzone_r   <= cfg_wdata[16:0];
        CFG_SATURATION: saturation_r <= cfg_wdata[16:0];
        CFG_GAIN:       gain_r       <= cfg_wdata[15:0];
        CFG_LOW_STOP:   low_stop_r   <= cfg_wdata[16:0];
        CFG_HIGH_STOP:  high_stop_r  <= cfg_wdata[16:0];
        CFG_MIN_DRIVE:  min_drive_r  <= cfg_wdata[6:0];
        CFG_PWM_TOP:    pwm_top_r    <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // ---------------- angle scaling: x = s*69120 + (M-1)/2, q = x / M
  logic [SAMPLE_BITS-1:0] smp_sel;
  logic [XW-1:0]          smp_ext, x_val, qm, rem_ang;
  logic [ANGLE_W-1:0]     q0_ang, ang_nxt;

  assign smp_sel = (state_r == ST_ASP_MUL || state_r == ST_ASP_FIX) ? sp_smp_r : ps_smp_r;
  assign smp_ext = XW'(smp_sel);
  assign x_val   = (smp_ext << 16) + (smp_ext << 11) + (smp_ext << 10) + (smp_ext << 9)
                 + ANG_HALF;
  assign q0_ang  = prod_r[ANG_K +: ANGLE_W];
  assign qm      = (XW'(q0_ang) << SAMPLE_BITS) - XW'(q0_ang);
  assign rem_ang = x_val - qm;
  // reciprocal estimate is at most one low
  assign ang_nxt = q0_ang + ANGLE_W'(rem_ang >= ANG_DIV);

  // ---------------- low-pass: f' = f + round(alpha*(x - f) / 2^16)
  logic                  fsp_sel;
  logic [ANGLE_W-1:0]    ang_sel;
  logic [STATE_W-1:0]    f_sel, fil_nxt;
  logic signed [25:0]    fdiff;
  logic signed [PW-1:0]  frnd, fstep;

  assign fsp_sel = (state_r == ST_FSP_MUL || state_r == ST_FSP_FIX);
  assign ang_sel = fsp_sel ? sp_ang_r : ps_ang_r;
  assign f_sel   = fsp_sel ? spf_r : psf_r;
  assign fdiff   = $signed({1'b0, ang_sel, 8'b0}) - $signed({1'b0, f_sel});
  assign frnd    = prod_r + $signed(PW'(32'd32768));
  assign fstep   = frnd >>> 16;
  assign fil_nxt = f_sel + fstep[STATE_W-1:0];

  // ---------------- error
  logic [ERR_W-1:0]    sp_q8, ps_q8, ae_nxt;
  logic signed [ERR_W:0] err_nxt;

  assign sp_q8   = ERR_W'((26'(spf_r) + 26'd128) >> 8);
  assign ps_q8   = ERR_W'((26'(psf_r) + 26'd128) >> 8);
  assign err_nxt = $signed({1'b0, sp_q8}) - $signed({1'b0, ps_q8});
  assign ae_nxt  = err_nxt[ERR_W] ? ERR_W'(-err_nxt) : err_nxt[ERR_W-1:0];

  // ---------------- gain, deadzone, saturation, end stops
  logic [PW-1:0]    gsum;
  logic [PW-17:0]   p_big;
  logic [MAG_W-1:0] mag_raw, mag_nxt, m_sel;
  logic             stop_cut;

  assign gsum  = $unsigned(prod_r) + PW'(32'd32768);
  assign p_big = gsum[PW-1:16];

  always_comb begin
    if (ae_r < {1'b0, deadzone_r}) begin
      mag_raw = '0;
    end else if (ae_r > {1'b0, saturation_r}) begin
      mag_raw = FULL_DRIVE;
    end else if (p_big > (PW-16)'(FULL_DRIVE)) begin
      mag_raw = FULL_DRIVE;
    end else begin
      mag_raw = p_big[MAG_W-1:0];
    end
  end

  assign stop_cut = (neg_r && pos_q8_r <= {1'b0, low_stop_r}) ||
                    (!neg_r && pos_q8_r >= {1'b0, high_stop_r});
  assign mag_nxt  = stop_cut ? '0 : mag_raw;
  assign m_sel    = (mag_r < min_drive_r) ? min_drive_r : mag_r;

  // ---------------- duty = max(m,min)*(top+1)/100, capped at top, 0 if m is 0
  logic [24:0]             q0d, qd;
  logic [31:0]             qd100, rem_d;
  logic [DUTY_W-1:0]       duty_nxt;
  logic signed [DRIVE_W-1:0] drive_nxt;

  assign q0d   = prod_r[DUTY_SHIFT +: 25];
  assign qd100 = (32'(q0d) << 6) + (32'(q0d) << 5) + (32'(q0d) << 2);
  assign rem_d = {1'b0, dval_r} - qd100;
  assign qd    = q0d + 25'(rem_d >= 32'd100);

  always_comb begin
    if (mag_r == '0) begin
      duty_nxt = '0;
    end else if (qd > {1'b0, pwm_top_r}) begin
      duty_nxt = pwm_top_r;
    end else begin
      duty_nxt = qd[DUTY_W-1:0];
    end
  end

  assign drive_nxt = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

  // ---------------- shared multiplier
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_nxt;

  always_comb begin
    case (state_r)
      ST_ASP_MUL, ST_APS_MUL: begin
        mul_a = MAW'(x_val);
        mul_b = ANG_RECIP;
      end
      ST_FSP_MUL, ST_FPS_MUL: begin
        mul_a = MAW'(alpha_r);
        mul_b = {{(MBW-26){fdiff[25]}}, fdiff};
      end
      ST_GAIN_MUL: begin
        mul_a = MAW'(ae_r);
        mul_b = MBW'(gain_r);
      end
      ST_DUTY_MUL: begin
        mul_a = MAW'({1'b0, pwm_top_r} + 25'd1);
        mul_b = MBW'(m_sel);
      end
      ST_RECIP_MUL: begin
        mul_a = MAW'(prod_r[30:0]);
        mul_b = MBW'(DUTY_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      spf_r       <= '0;
      psf_r       <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_DUTY_FIX) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            sp_smp_r <= in_ch.setpoint_sample;
            ps_smp_r <= in_ch.position_sample;
            state_r  <= ST_ASP_MUL;
          end
        end
        ST_ASP_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_ASP_FIX;
        end
        ST_ASP_FIX: begin
          sp_ang_r <= FULL_Q8 - ang_nxt;
          state_r  <= ST_APS_MUL;
        end
        ST_APS_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_APS_FIX;
        end
        ST_APS_FIX: begin
          ps_ang_r <= ang_nxt;
          state_r  <= ST_FSP_MUL;
        end
        ST_FSP_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_FSP_FIX;
        end
        ST_FSP_FIX: begin
          spf_r   <= fil_nxt;
          state_r <= ST_FPS_MUL;
        end
        ST_FPS_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_FPS_FIX;
        end
        ST_FPS_FIX: begin
          psf_r   <= fil_nxt;
          state_r <= ST_ERR;
        end
        ST_ERR: begin
          err_r    <= err_nxt;
          ae_r     <= ae_nxt;
          neg_r    <= err_nxt[ERR_W];
          pos_q8_r <= ps_q8;
          state_r  <= ST_GAIN_MUL;
        end
        ST_GAIN_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_GAIN_FIX;
        end
        ST_GAIN_FIX: begin
          mag_r   <= mag_nxt;
          state_r <= ST_DUTY_MUL;
        end
        ST_DUTY_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_RECIP_MUL;
        end
        ST_RECIP_MUL: begin
          dval_r  <= prod_r[30:0];
          prod_r  <= prod_nxt;
          state_r <= ST_DUTY_FIX;
        end
        ST_DUTY_FIX: begin
          // hold here while the previous beat is still unclaimed
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            drive_r     <= drive_nxt;
            forward_r   <= !(neg_r && mag_r != '0);
            duty_r      <= duty_nxt;
            error_r     <= err_r[ERR_W-1:0];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_percent = drive_r;
  assign out_ch.forward       = forward_r;
  assign out_ch.duty_compare  = duty_r;
  assign out_ch.error_angle   = error_r;

  // ---------------- checks
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while sequencer busy");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive_percent <= 8'sd100 && out_ch.drive_percent >= -8'sd100))
    else $error("drive out of range");

  a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.drive_percent == '0) |-> (out_ch.duty_compare == '0 &&
                                                      out_ch.forward))
    else $error("zero drive with nonzero duty or reverse direction");

  a_duty_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_compare <= pwm_top_r)
    else $error("duty above pwm top");

  a_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.forward == !out_ch.drive_percent[DRIVE_W-1]))
    else $error("direction disagrees with drive sign");

endmodule
